/* rtl/cpi_pkg.sv */
package cpi_pkg;

	localparam int ZW = 32;
	localparam int TW = 17;
	localparam logic [TW-1:0] ONE_T = 17'd65536;

	typedef logic [ZW-1:0] zang_t;

	function automatic zang_t arc_at(input int i);
		zang_t r;
		case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// floor(2^62 / g) with g = 2^32 * prod(1 + 2^-2i) for n stages, elaboration time only
	function automatic longint gain_q(input int n);
		longint g;
		longint q;
		g = longint'(1) << 32;
		for (int i = 0; i < n; i++) g = g + (g >>> (2 * i));
		q = longint'((64'd1 << 62) / 64'(g));
		return q;
	endfunction

	typedef struct packed {
		logic lin;
		logic [TW-1:0] t;
	} cls_t;

endpackage

/* rtl/cpi_front.sv */
module cpi_front #(
	parameter int W = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_v,
	input logic signed [W-1:0] ar,
	input logic signed [W-1:0] ai,
	input logic signed [W-1:0] br,
	input logic signed [W-1:0] bi,
	input logic [16:0] t_in,
	output logic out_v,
	output cpi_pkg::cls_t cls_s1,
	output logic signed [W-1:0] ar_s1,
	output logic signed [W-1:0] ai_s1,
	output logic signed [W-1:0] br_s1,
	output logic signed [W-1:0] bi_s1,
	input logic stall
);
	import cpi_pkg::*;

	logic v_q;
	assign out_v = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!stall) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ar_s1 <= ar;
			ai_s1 <= ai;
			br_s1 <= br;
			bi_s1 <= bi;
			cls_s1.t <= (t_in > ONE_T) ? ONE_T : t_in;
			cls_s1.lin <= ((ar == '0) && (ai == '0)) || ((br == '0) && (bi == '0));
		end
	end
endmodule

/* rtl/cpi_back.sv */
module cpi_back #(
	parameter int W = 16,
	parameter int N = 16
) (
	input logic clk,
	input logic arst_n,
	input logic stall,
	input logic in_v,
	input cpi_pkg::cls_t cls,
	input logic signed [W-1:0] ar,
	input logic signed [W-1:0] ai,
	input logic signed [W-1:0] br,
	input logic signed [W-1:0] bi,
	output logic out_v,
	output logic signed [W-1:0] re_o,
	output logic signed [W-1:0] im_o,
	output logic lin_o,
	output logic sat_o
);
	import cpi_pkg::*;

	localparam int NS = (N > 32) ? 32 : N;
	localparam int G = 32 - W;
	localparam int XW = 36;
	localparam int LAT = 2 * NS + 5;
	localparam longint QL = gain_q(NS);
	localparam logic signed [33:0] Q = 34'(QL);
	localparam int SH = 30 + G;

	logic [LAT-1:0] v_p;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= '0;
		end else if (!stall) begin
			v_p <= {v_p[LAT-2:0], in_v};
		end
	end
	assign out_v = v_p[LAT-1];

	// side data for lerp and flag, carried along
	typedef struct packed {
		cls_t c;
		logic signed [W-1:0] ar;
		logic signed [W-1:0] ai;
		logic signed [W-1:0] br;
		logic signed [W-1:0] bi;
	} side_t;
	side_t sd [0:LAT-1];
	assign sd[0] = '{c: cls, ar: ar, ai: ai, br: br, bi: bi};
	for (genvar k = 0; k < LAT - 1; k++) begin : g_sd
		always_ff @(posedge clk) if (!stall) sd[k+1] <= sd[k];
	end

	// vectoring, two lanes
	logic signed [XW-1:0] xa [0:NS], ya [0:NS], xb [0:NS], yb [0:NS];
	zang_t za [0:NS], zb [0:NS];
	always_comb begin
		logic signed [XW-1:0] x0, y0, x1, y1;
		x0 = XW'(ar) <<< G;
		y0 = XW'(ai) <<< G;
		x1 = XW'(br) <<< G;
		y1 = XW'(bi) <<< G;
		xa[0] = x0[XW-1] ? -x0 : x0;
		ya[0] = x0[XW-1] ? -y0 : y0;
		za[0] = x0[XW-1] ? 32'h80000000 : '0;
		xb[0] = x1[XW-1] ? -x1 : x1;
		yb[0] = x1[XW-1] ? -y1 : y1;
		zb[0] = x1[XW-1] ? 32'h80000000 : '0;
	end
	for (genvar i = 0; i < NS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (!stall) begin
				if (!ya[i][XW-1]) begin
					xa[i+1] <= xa[i] + (ya[i] >>> i);
					ya[i+1] <= ya[i] - (xa[i] >>> i);
					za[i+1] <= za[i] + arc_at(i);
				end else begin
					xa[i+1] <= xa[i] - (ya[i] >>> i);
					ya[i+1] <= ya[i] + (xa[i] >>> i);
					za[i+1] <= za[i] - arc_at(i);
				end
				if (!yb[i][XW-1]) begin
					xb[i+1] <= xb[i] + (yb[i] >>> i);
					yb[i+1] <= yb[i] - (xb[i] >>> i);
					zb[i+1] <= zb[i] + arc_at(i);
				end else begin
					xb[i+1] <= xb[i] - (yb[i] >>> i);
					yb[i+1] <= yb[i] + (xb[i] >>> i);
					zb[i+1] <= zb[i] - arc_at(i);
				end
			end
		end
	end

	// interp stage 1: products
	side_t sv;
	assign sv = sd[NS];
	logic [15:0] anga_c, angb_c, dl;
	logic signed [16:0] dls;
	logic [31:0] tza, tzb;
	assign tza = za[NS] + 32'h8000;
	assign tzb = zb[NS] + 32'h8000;
	assign anga_c = tza[31:16];
	assign angb_c = tzb[31:16];
	assign dl = angb_c - anga_c;
	assign dls = (dl > 16'd32768) ? ($signed({1'b0, dl}) - 17'sd65536) : $signed({1'b0, dl});

	logic signed [35:0] dp_s1;
	logic signed [55:0] mp_s1;
	logic signed [XW-1:0] ma_s1;
	logic [15:0] anga_s1;
	logic signed [W+18:0] lre_s1, lim_s1;
	always_ff @(posedge clk) begin
		if (!stall) begin
			dp_s1 <= 36'(dls) * $signed({1'b0, sv.c.t});
			mp_s1 <= (56'(xb[NS]) - 56'(xa[NS])) * $signed({1'b0, sv.c.t});
			ma_s1 <= xa[NS];
			anga_s1 <= anga_c;
			lre_s1 <= ((W+19)'(sv.br) - (W+19)'(sv.ar)) * $signed({1'b0, sv.c.t});
			lim_s1 <= ((W+19)'(sv.bi) - (W+19)'(sv.ai)) * $signed({1'b0, sv.c.t});
		end
	end

	// interp stage 2: sums and rotation setup
	logic signed [35:0] dr;
	logic signed [55:0] mr;
	logic [15:0] ang;
	logic signed [XW-1:0] mag;
	logic [31:0] z0, zr;
	assign dr = (dp_s1 + 36'sd32768) >>> 16;
	assign mr = (mp_s1 + 56'sd32768) >>> 16;
	assign ang = anga_s1 + dr[15:0];
	assign mag = ma_s1 + XW'(mr);
	assign z0 = {ang, 16'h0};
	logic qsel;
	assign qsel = (z0 - 32'h40000000) < 32'h80000000;
	assign zr = qsel ? (z0 - 32'h80000000) : z0;

	logic signed [XW-1:0] xr [0:NS], yr [0:NS];
	logic signed [32:0] sr [0:NS];
	logic signed [W+18:0] lre_s2, lim_s2;
	always_ff @(posedge clk) begin
		if (!stall) begin
			xr[0] <= qsel ? -mag : mag;
			yr[0] <= '0;
			sr[0] <= 33'(signed'(zr));
			lre_s2 <= lre_s1;
			lim_s2 <= lim_s1;
		end
	end
	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (!stall) begin
				if (!sr[i][32]) begin
					xr[i+1] <= xr[i] - (yr[i] >>> i);
					yr[i+1] <= yr[i] + (xr[i] >>> i);
					sr[i+1] <= sr[i] - $signed({1'b0, arc_at(i)});
				end else begin
					xr[i+1] <= xr[i] + (yr[i] >>> i);
					yr[i+1] <= yr[i] - (xr[i] >>> i);
					sr[i+1] <= sr[i] + $signed({1'b0, arc_at(i)});
				end
			end
		end
	end

	// linear path carried beside rotation
	logic signed [W+18:0] lre_d [0:NS], lim_d [0:NS];
	assign lre_d[0] = lre_s2;
	assign lim_d[0] = lim_s2;
	for (genvar i = 0; i < NS; i++) begin : g_ld
		always_ff @(posedge clk) if (!stall) begin
			lre_d[i+1] <= lre_d[i];
			lim_d[i+1] <= lim_d[i];
		end
	end

	// gain multiply, 36 x 34 split in two halves
	logic signed [XW-1:0] xh, yh;
	assign xh = xr[NS];
	assign yh = yr[NS];
	logic signed [XW+18:0] xlo_s3, ylo_s3, xhi_s3, yhi_s3;
	logic signed [W+18:0] lre_s3, lim_s3;
	always_ff @(posedge clk) begin
		if (!stall) begin
			xlo_s3 <= (XW+19)'(xh) * $signed({1'b0, Q[16:0]});
			ylo_s3 <= (XW+19)'(yh) * $signed({1'b0, Q[16:0]});
			xhi_s3 <= (XW+19)'(xh) * (XW+19)'(Q[33:17]);
			yhi_s3 <= (XW+19)'(yh) * (XW+19)'(Q[33:17]);
			lre_s3 <= lre_d[NS];
			lim_s3 <= lim_d[NS];
		end
	end
	logic signed [71:0] xp_s4, yp_s4;
	logic signed [W+18:0] lre_s4, lim_s4;
	always_ff @(posedge clk) begin
		if (!stall) begin
			xp_s4 <= (72'(xhi_s3) <<< 17) + 72'(xlo_s3);
			yp_s4 <= (72'(yhi_s3) <<< 17) + 72'(ylo_s3);
			lre_s4 <= lre_s3;
			lim_s4 <= lim_s3;
		end
	end

	// final: round, lerp or polar, clip
	side_t sf;
	assign sf = sd[LAT - 1];
	logic signed [71:0] xf, yf;
	logic signed [W+18:0] lr, li;
	logic signed [W+19:0] vre, vim;
	logic signed [W+19:0] HI, LO;
	assign HI = (W+20)'((64'sd1 <<< (W - 1)) - 1);
	assign LO = -(W+20)'(64'sd1 <<< (W - 1));
	assign xf = (xp_s4 + (72'sd1 <<< (SH - 1))) >>> SH;
	assign yf = (yp_s4 + (72'sd1 <<< (SH - 1))) >>> SH;
	assign lr = (lre_s4 + (W+19)'(32768)) >>> 16;
	assign li = (lim_s4 + (W+19)'(32768)) >>> 16;
	always_comb begin
		if (sf.c.lin) begin
			vre = (W+20)'(sf.ar) + (W+20)'(lr);
			vim = (W+20)'(sf.ai) + (W+20)'(li);
		end else begin
			vre = (xf > 72'(HI)) ? HI + 1 : ((xf < 72'(LO)) ? LO - 1 : (W+20)'(xf));
			vim = (yf > 72'(HI)) ? HI + 1 : ((yf < 72'(LO)) ? LO - 1 : (W+20)'(yf));
		end
	end
	logic sre, sim;
	assign sre = (vre > HI) || (vre < LO);
	assign sim = (vim > HI) || (vim < LO);
	always_ff @(posedge clk) begin
		if (!stall) begin
			re_o <= (vre > HI) ? W'(HI) : ((vre < LO) ? W'(LO) : W'(vre));
			im_o <= (vim > HI) ? W'(HI) : ((vim < LO) ? W'(LO) : W'(vim));
			lin_o <= sf.c.lin;
			sat_o <= sre || sim;
		end
	end
endmodule

/* rtl/cpi_queue.sv */
module cpi_queue #(
	parameter int DW = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input logic [DW-1:0] wdata,
	input logic rd,
	output logic [DW-1:0] rdata,
	output logic empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH+1);
	logic [DW-1:0] mem [0:DEPTH-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] mcnt_q;
	logic [DW-1:0] rdata_q;
	logic ov_q;
	logic load, mem_wr, mem_rd;

	// output register holds the head word; memory holds the rest
	assign load = !ov_q || rd;
	assign mem_rd = load && (mcnt_q != '0);
	assign mem_wr = wr && !(load && (mcnt_q == '0));
	assign rdata = rdata_q;
	assign empty = !ov_q;
	assign count = mcnt_q + NW'(ov_q);

	always_ff @(posedge clk) begin
		if (mem_wr) mem[wp_q] <= wdata;
		if (mem_rd) rdata_q <= mem[rp_q];
		else if (load && wr) rdata_q <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			mcnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) ov_q <= (mcnt_q != '0) || wr;
			if (mem_wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (mem_rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			mcnt_q <= mcnt_q + (mem_wr ? 1'b1 : 1'b0) - (mem_rd ? 1'b1 : 1'b0);
		end
	end
endmodule

/* rtl/complex_polar_interpolate_unit.sv */
// Polar interpolation of two complex points, fully pipelined: one word in
// per cycle while the result side keeps up. A result word passes the front
// register, two unrolled CORDIC chains for vectoring and rotation, the
// interpolate, gain multiply and clip stages, then the output queue, on its
// way to the outputs. The front stage classifies zero endpoints and clamps
// frac; the back pipeline never stalls, since full is raised once words in
// flight plus words waiting reach the output queue depth.
module complex_polar_interpolate_unit #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [COMPONENT_WIDTH-1:0] a_re,
	input logic signed [COMPONENT_WIDTH-1:0] a_im,
	input logic signed [COMPONENT_WIDTH-1:0] b_re,
	input logic signed [COMPONENT_WIDTH-1:0] b_im,
	input logic [16:0] frac,
	output logic empty,
	input logic pop,
	output logic signed [COMPONENT_WIDTH-1:0] out_re,
	output logic signed [COMPONENT_WIDTH-1:0] out_im,
	output logic linear_used,
	output logic saturated
);
	import cpi_pkg::*;

	localparam int W = COMPONENT_WIDTH;
	localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int LAT = 2 * NS + 6;
	localparam int ODEPTH = LAT + 4;
	localparam int MW = 2 * W + 2;
	localparam int CW = $clog2(ODEPTH + 1);

	logic stall;
	assign stall = 1'b0;

	logic f_v;
	cls_t f_cls;
	logic signed [W-1:0] f_ar, f_ai, f_br, f_bi;
	logic acc;
	assign acc = push && !full;

	cpi_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .in_v(acc),
		.ar(a_re), .ai(a_im), .br(b_re), .bi(b_im), .t_in(frac),
		.out_v(f_v), .cls_s1(f_cls),
		.ar_s1(f_ar), .ai_s1(f_ai), .br_s1(f_br), .bi_s1(f_bi),
		.stall(stall)
	);

	logic b_v, b_lin, b_sat;
	logic signed [W-1:0] b_re_o, b_im_o;
	cpi_back #(.W(W), .N(NS)) u_back (
		.clk(clk), .arst_n(arst_n), .stall(stall), .in_v(f_v), .cls(f_cls),
		.ar(f_ar), .ai(f_ai), .br(f_br), .bi(f_bi),
		.out_v(b_v), .re_o(b_re_o), .im_o(b_im_o), .lin_o(b_lin), .sat_o(b_sat)
	);

	// credit: items in flight plus queued never exceed queue depth
	logic [CW-1:0] infl_q, qcnt;
	logic do_pop;
	assign do_pop = pop && !empty;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else begin
			infl_q <= infl_q + (acc ? 1'b1 : 1'b0) - (b_v ? 1'b1 : 1'b0);
		end
	end
	assign full = (CW'(infl_q + qcnt) >= CW'(ODEPTH));

	logic [MW-1:0] qd;
	cpi_queue #(.DW(MW), .DEPTH(ODEPTH)) u_oq (
		.clk(clk), .arst_n(arst_n), .wr(b_v),
		.wdata({b_re_o, b_im_o, b_lin, b_sat}),
		.rd(do_pop), .rdata(qd), .empty(empty), .count(qcnt)
	);
	assign out_re = qd[MW-1 -: W];
	assign out_im = qd[W+1 -: W];
	assign linear_used = qd[1];
	assign saturated = qd[0];

`ifndef ASSERT_OFF
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		b_v |-> (qcnt < CW'(ODEPTH) || do_pop)) else $error("queue overflow");
	a_full_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(infl_q + qcnt) <= CW'(ODEPTH))) else $error("credit overrun");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (qcnt == '0)) else $error("empty mismatch");
`endif
endmodule
